// ===== rtl/mvm_pkg.sv =====
// Shared types and constants for the matrix-vector multiplier.
// No dependencies; every other file depends on this package.
package mvm_pkg;

  localparam int ELEM_W          = 32;
  localparam int ROW_W           = 16;
  localparam int COLS_CFG_W      = 11;
  localparam int ROWS_CFG_W      = 17;
  localparam int CFG_W           = 17;
  localparam int CFG_IDX_W       = 1;
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int ROW_LIMIT       = 65536;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // element kinds on the input channel
  localparam logic KIND_VECTOR = 1'b0;
  localparam logic KIND_MATRIX = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMN_COUNT = 1'b0,
    REG_ROW_COUNT    = 1'b1
  } cfg_idx_e;

  // one matrix element with its vector operand, handed from front to back
  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [ELEM_W-1:0] vec;
    logic              row_end;
    logic [ROW_W-1:0]  row;
    logic              is_last;
  } mvm_op_t;

endpackage

// ===== rtl/mvm_if.sv =====
// Valid/ready channel interfaces for the element input and row-sum output.
// Depends on mvm_pkg for field widths.
interface mvm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [mvm_pkg::ELEM_W-1:0]   element_value;

  modport source (output valid, kind, element_value, input ready);
  modport sink   (input valid, kind, element_value, output ready);
endinterface

interface mvm_out_if;
  logic                         valid;
  logic                         ready;
  logic [mvm_pkg::ELEM_W-1:0]   row_sum;
  logic [mvm_pkg::ROW_W-1:0]    row_index;
  logic                         last;

  modport source (output valid, row_sum, row_index, last, input ready);
  modport sink   (input valid, row_sum, row_index, last, output ready);
endinterface

// ===== rtl/matrix_vector_multiply.sv =====
// Streamed integer matrix-vector multiply, top level.
// Element path: front register, operation queue, product register, output.
// Throughput: one element per cycle when neither the queue nor the output stalls.
// Reset (async, active low) sets 1 column, 1 row, all positions and the sum to 0;
// the vector store is not cleared. Depends on mvm_pkg, mvm_if and the mvm_* units.
module matrix_vector_multiply #(
  parameter int MAX_COLUMNS = mvm_pkg::DEF_MAX_COLUMNS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mvm_pkg::CFG_W-1:0]      cfg_wdata_i,
  mvm_in_if.sink                         in_i,
  mvm_out_if.source                      out_o
);
  import mvm_pkg::*;

  logic               q_push, q_pop, q_empty, q_full;
  logic [QCNT_W-1:0]  q_count;
  mvm_op_t            front_op, back_op;

  mvm_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_i),
    .q_count_i  (q_count),
    .push_o     (q_push),
    .op_o       (front_op)
  );

  mvm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .op_i   (front_op),
    .pop_i  (q_pop),
    .op_o   (back_op),
    .empty_o(q_empty),
    .full_o (q_full),
    .count_o(q_count)
  );

  mvm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_we_i),
    .op_valid_i(!q_empty),
    .op_i      (back_op),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );

  // the front end's admission check must leave room for every request
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("operation queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("operation queue underflow");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !in_i.ready)
    else $error("input accepted while queue full");

endmodule

// ===== rtl/mvm_front.sv =====
// Front end: accepts requests, holds the vector store and position counters,
// and issues one operation per matrix element. Depends on mvm_pkg, mvm_if.
module mvm_front #(
  parameter int MAX_COLUMNS = mvm_pkg::DEF_MAX_COLUMNS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mvm_pkg::CFG_W-1:0]       cfg_wdata_i,
  mvm_in_if.sink                          in_i,
  input  logic [mvm_pkg::QCNT_W-1:0]      q_count_i,
  output logic                            push_o,
  output mvm_pkg::mvm_op_t                op_o
);
  import mvm_pkg::*;

  localparam int AW   = $clog2(MAX_COLUMNS);
  localparam int EC_W = $clog2(MAX_COLUMNS + 1);

  logic [ELEM_W-1:0] mem [MAX_COLUMNS];

  logic [EC_W-1:0]       eff_cols_q;
  logic [ROWS_CFG_W-1:0] eff_rows_q;
  logic [AW-1:0]         ld_q, ld_d;
  logic [AW-1:0]         col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic                  s1_valid_q;
  logic [ELEM_W-1:0]     rdata_q;
  logic [ELEM_W-1:0]     s1_value_q;
  logic                  s1_row_end_q;
  logic [ROW_W-1:0]      s1_row_q;
  logic                  s1_is_last_q;

  logic                  accept, wr_en, rd_en;
  logic                  ld_end, col_end, row_end_last;
  logic [COLS_CFG_W-1:0] cfg_cols;
  logic [ROWS_CFG_W-1:0] cfg_rows;
  logic [EC_W-1:0]       cols_clamped;
  logic [ROWS_CFG_W-1:0] rows_clamped;

  // room must remain for the operation already in flight to the queue
  assign in_i.ready = (32'(q_count_i) + 32'(s1_valid_q)) < QUEUE_DEPTH;
  assign accept     = in_i.valid && in_i.ready;
  assign wr_en      = accept && (in_i.kind == KIND_VECTOR);
  assign rd_en      = accept && (in_i.kind == KIND_MATRIX);

  assign ld_end       = (32'(ld_q) + 32'd1) == 32'(eff_cols_q);
  assign col_end      = (32'(col_q) + 32'd1) == 32'(eff_cols_q);
  assign row_end_last = (32'(row_q) + 32'd1) >= 32'(eff_rows_q);

  assign cfg_cols = cfg_wdata_i[COLS_CFG_W-1:0];
  assign cfg_rows = cfg_wdata_i[ROWS_CFG_W-1:0];

  always_comb begin
    if (cfg_cols == '0) begin
      cols_clamped = EC_W'(1);
    end else if (32'(cfg_cols) > MAX_COLUMNS) begin
      cols_clamped = EC_W'(MAX_COLUMNS);
    end else begin
      cols_clamped = EC_W'(cfg_cols);
    end
    if (cfg_rows == '0) begin
      rows_clamped = ROWS_CFG_W'(1);
    end else if (32'(cfg_rows) > ROW_LIMIT) begin
      rows_clamped = ROWS_CFG_W'(ROW_LIMIT);
    end else begin
      rows_clamped = cfg_rows;
    end
  end

  always_comb begin
    ld_d  = ld_q;
    col_d = col_q;
    row_d = row_q;
    if (wr_en) begin
      ld_d = ld_end ? '0 : ld_q + AW'(1);
    end
    if (rd_en) begin
      col_d = col_end ? '0 : col_q + AW'(1);
      if (col_end) begin
        row_d = row_end_last ? '0 : row_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_cols_q <= EC_W'(1);
      eff_rows_q <= ROWS_CFG_W'(1);
      ld_q       <= '0;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= rd_en;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          REG_COLUMN_COUNT: eff_cols_q <= cols_clamped;
          REG_ROW_COUNT:    eff_rows_q <= rows_clamped;
          default:          ;
        endcase
        ld_q  <= '0;
        col_q <= '0;
        row_q <= '0;
      end else begin
        ld_q  <= ld_d;
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // vector store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ld_q] <= in_i.element_value;
    end
    if (rd_en) begin
      rdata_q <= mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_value_q   <= in_i.element_value;
      s1_row_end_q <= col_end;
      s1_row_q     <= row_q;
      s1_is_last_q <= row_end_last;
    end
  end

  assign push_o        = s1_valid_q;
  assign op_o.value    = s1_value_q;
  assign op_o.vec      = rdata_q;
  assign op_o.row_end  = s1_row_end_q;
  assign op_o.row      = s1_row_q;
  assign op_o.is_last  = s1_is_last_q;

endmodule

// ===== rtl/mvm_queue.sv =====
// Short FIFO of operations between the front and back ends.
// Depends on mvm_pkg for the record type and depth.
module mvm_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  mvm_pkg::mvm_op_t            op_i,
  input  logic                        pop_i,
  output mvm_pkg::mvm_op_t            op_o,
  output logic                        empty_o,
  output logic                        full_o,
  output logic [mvm_pkg::QCNT_W-1:0]  count_o
);
  import mvm_pkg::*;

  mvm_op_t            slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (32'(count_q) == QUEUE_DEPTH);
  assign count_o = count_q;
  assign op_o    = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// ===== rtl/mvm_back.sv =====
// Back end: multiply stage, running row accumulator and output register.
// Depends on mvm_pkg and mvm_if.
module mvm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              op_valid_i,
  input  mvm_pkg::mvm_op_t  op_i,
  output logic              pop_o,
  mvm_out_if.source         out_o
);
  import mvm_pkg::*;

  logic              m_valid_q;
  logic [ELEM_W-1:0] m_prod_q;
  logic              m_row_end_q;
  logic [ROW_W-1:0]  m_row_q;
  logic              m_last_q;
  logic [ELEM_W-1:0] acc_q;
  logic              out_valid_q;
  logic [ELEM_W-1:0] out_sum_q;
  logic [ROW_W-1:0]  out_row_q;
  logic              out_last_q;

  logic              out_free, m_adv, pop;
  logic [ELEM_W-1:0] sum;

  assign out_free = !out_valid_q || out_o.ready;
  assign m_adv    = m_valid_q && (!m_row_end_q || out_free);
  assign pop      = op_valid_i && (!m_valid_q || m_adv);
  assign pop_o    = pop;
  assign sum      = acc_q + m_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        m_valid_q <= 1'b1;
      end else if (m_adv) begin
        m_valid_q <= 1'b0;
      end
      if (clear_i) begin
        acc_q <= '0;
      end else if (m_adv) begin
        acc_q <= m_row_end_q ? '0 : sum;
      end
      if (m_adv && m_row_end_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // low half of the product is all the wrapped sum needs
  always_ff @(posedge clk_i) begin
    if (pop) begin
      m_prod_q    <= ELEM_W'(op_i.value * op_i.vec);
      m_row_end_q <= op_i.row_end;
      m_row_q     <= op_i.row;
      m_last_q    <= op_i.is_last;
    end
    if (m_adv && m_row_end_q) begin
      out_sum_q  <= sum;
      out_row_q  <= m_row_q;
      out_last_q <= m_last_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.row_sum   = out_sum_q;
  assign out_o.row_index = out_row_q;
  assign out_o.last      = out_last_q;

endmodule

// ===== tb/mvm_row_checker.sv =====
`timescale 1ns / 100ps
// Row-sum checker for the matrix-vector multiplier: watches the register port, the element channel and
// the row-sum channel, predicts each row sum and compares it with what the block emits.
// Depends on mvm_pkg and the mvm_in_if / mvm_out_if interfaces.
module mvm_row_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mvm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mvm_pkg::CFG_W-1:0]     cfg_wdata_i,
  mvm_in_if                             elem_ch,
  mvm_out_if                            sum_ch,
  output int                            error_count_o,
  output int                            pending_o
);
  import mvm_pkg::*;

  typedef struct packed {
    logic [ELEM_W-1:0] sum;
    logic [ROW_W-1:0]  row;
    logic              last;
  } row_result_t;

  logic [ELEM_W-1:0]     vector_mem [DEF_MAX_COLUMNS];
  logic [COLS_CFG_W-1:0] columns_reg;
  logic [ROWS_CFG_W-1:0] rows_reg;
  int unsigned           load_pos;
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [ELEM_W-1:0]     running_sum;
  row_result_t           expected_rows [$];
  int                    errors = 0;

  function automatic int unsigned active_columns();
    if (columns_reg == '0) return 1;
    if (columns_reg > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
    return columns_reg;
  endfunction

  function automatic int unsigned active_rows();
    if (rows_reg == '0) return 1;
    if (rows_reg > ROW_LIMIT) return ROW_LIMIT;
    return rows_reg;
  endfunction

  task automatic restart_row_stream();
    load_pos    = 0;
    col_pos     = 0;
    row_pos     = 0;
    running_sum = '0;
  endtask

  task automatic accept_element(logic kind, logic [ELEM_W-1:0] value);
    int unsigned cols;
    int unsigned rows;
    int unsigned pos;
    row_result_t res;
    cols = active_columns();
    rows = active_rows();
    if (kind == KIND_VECTOR) begin
      pos = (load_pos >= cols) ? 0 : load_pos;
      vector_mem[pos] = value;
      load_pos = (pos + 1 >= cols) ? 0 : pos + 1;
    end else begin
      pos = (col_pos >= cols) ? 0 : col_pos;
      running_sum = running_sum + value * vector_mem[pos];
      if (pos + 1 < cols) begin
        col_pos = pos + 1;
      end else begin
        // row complete: emit and start the next row from zero
        pos = (row_pos >= rows) ? 0 : row_pos;
        res.sum  = running_sum;
        res.row  = pos[ROW_W-1:0];
        res.last = (pos + 1 >= rows);
        expected_rows.push_back(res);
        running_sum = '0;
        col_pos = 0;
        row_pos = res.last ? 0 : pos + 1;
      end
    end
  endtask

  task automatic check_row(row_result_t got);
    row_result_t want;
    if (expected_rows.size() == 0) begin
      $display("%0t: unexpected row result: expected none, got sum %0d row %0d last %0b",
               $time, $signed(got.sum), got.row, got.last);
      errors++;
      return;
    end
    want = expected_rows.pop_front();
    if (got.sum !== want.sum) begin
      $display("%0t: row_sum mismatch: expected %0d, got %0d",
               $time, $signed(want.sum), $signed(got.sum));
      errors++;
    end
    if (got.row !== want.row) begin
      $display("%0t: row_index mismatch: expected %0d, got %0d", $time, want.row, got.row);
      errors++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, got.last);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_reg = 1;
      rows_reg    = 1;
      restart_row_stream();
      expected_rows.delete();
    end else begin
      if (sum_ch.valid && sum_ch.ready) begin
        check_row(row_result_t'{sum_ch.row_sum, sum_ch.row_index, sum_ch.last});
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_COLUMN_COUNT: columns_reg = cfg_wdata_i[COLS_CFG_W-1:0];
          REG_ROW_COUNT:    rows_reg    = cfg_wdata_i[ROWS_CFG_W-1:0];
          default: ;
        endcase
        restart_row_stream();
      end
      if (elem_ch.valid && elem_ch.ready) begin
        accept_element(elem_ch.kind, elem_ch.element_value);
      end
    end
    pending_o     = expected_rows.size();
    error_count_o = errors;
  end

endmodule

// ===== tb/matrix_vector_multiply_test.sv =====
`timescale 1ns / 100ps
// Top of the matrix-vector multiplier testbench: clock, reset, register writes,
// element requests and result back-pressure; mvm_row_checker does the checking.
// Depends on mvm_pkg, mvm_if, matrix_vector_multiply and mvm_row_checker.
module matrix_vector_multiply_test;
  import mvm_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 530;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   row_errors;
  int                   rows_pending;
  int                   cycles = 0;
  int                   stall_left = 0;
  int                   items_sent = 0;
  bit                   quiet_in = 1'b0;
  bit                   quiet_out = 1'b0;
  int unsigned          eff_cols = 1;
  int unsigned          eff_rows = 1;
  int unsigned          load_pos = 0;
  bit [DEF_MAX_COLUMNS-1:0] loaded = '0;

  mvm_in_if  elem_ch ();
  mvm_out_if sum_ch ();

  matrix_vector_multiply DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (elem_ch),
    .out_o       (sum_ch)
  );

  mvm_row_checker row_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .elem_ch       (elem_ch),
    .sum_ch        (sum_ch),
    .error_count_o (row_errors),
    .pending_o     (rows_pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d rows outstanding", $time, rows_pending);
      $display("matrix_vector_multiply test failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_size(int unsigned word, int unsigned limit);
    if (word == 0) return 1;
    if (word > limit) return limit;
    return word;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 1);
      4, 5: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit vector_complete();
    for (int i = 0; i < eff_cols; i++) begin
      if (!loaded[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      sum_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      sum_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap(quiet_out);
    end
  end

  // entered and left at a falling edge; valid stays high on exit
  task automatic send_item(logic kind, logic [ELEM_W-1:0] value);
    int gap;
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      elem_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    elem_ch.valid         <= 1'b1;
    elem_ch.kind          <= kind;
    elem_ch.element_value <= value;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_vector(logic [ELEM_W-1:0] value);
    loaded[load_pos] = 1'b1;
    load_pos = (load_pos + 1 >= eff_cols) ? 0 : load_pos + 1;
    send_item(KIND_VECTOR, value);
  endtask

  task automatic idle_until_drained();
    elem_ch.valid <= 1'b0;
    do @(negedge clk); while (rows_pending != 0);
  endtask

  // drained plus latency, so a trailing vector load or partial row has settled
  task automatic settle();
    idle_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic set_sizes(logic [CFG_W-1:0] cols_word, logic [CFG_W-1:0] rows_word);
    settle();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_COLUMN_COUNT, cols_word);
      write_reg(REG_ROW_COUNT, rows_word);
    end else begin
      write_reg(REG_ROW_COUNT, rows_word);
      write_reg(REG_COLUMN_COUNT, cols_word);
    end
    cfg_we <= 1'b0;
    eff_cols = clamp_size(cols_word[COLS_CFG_W-1:0], DEF_MAX_COLUMNS);
    eff_rows = clamp_size(rows_word, ROW_LIMIT);
    load_pos = 0;
  endtask

  task automatic stream_matrix(int n, int pause_at, bit noisy);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) idle_until_drained();
      if (noisy && $urandom_range(0, 15) == 0) send_vector(pick_value());
      send_item(KIND_MATRIX, pick_value());
    end
  endtask

  task automatic random_phase();
    logic [CFG_W-1:0] cols_word;
    logic [CFG_W-1:0] rows_word;
    int unsigned      r;
    int               n_rows;
    int               cap;
    int               n;
    int               pause_at;
    r = $urandom_range(0, 99);
    if (r < 10)      cols_word = 0;
    else if (r < 75) cols_word = $urandom_range(1, 8);
    else             cols_word = $urandom_range(9, 48);
    // junk above the column field
    if ($urandom_range(0, 3) == 0) cols_word[CFG_W-1:COLS_CFG_W] = $urandom;
    r = $urandom_range(0, 99);
    if (r < 10)      rows_word = 0;
    else if (r < 70) rows_word = $urandom_range(1, 4);
    else if (r < 85) rows_word = $urandom_range(5, 16);
    else             rows_word = $urandom_range(ROW_LIMIT, 2 * ROW_LIMIT - 1);
    quiet_in  = ($urandom_range(0, 4) == 0);
    quiet_out = ($urandom_range(0, 4) == 0);
    set_sizes(cols_word, rows_word);

    if (!vector_complete() || $urandom_range(0, 3) != 0) begin
      n = eff_cols;
      if ($urandom_range(0, 4) == 0) n += $urandom_range(1, eff_cols);
      repeat (n) send_vector(pick_value());
    end

    n_rows = (eff_rows <= 16) ? $urandom_range(1, 2 * eff_rows) : $urandom_range(1, 4);
    cap = 120 / eff_cols;
    if (cap < 1) cap = 1;
    if (n_rows > cap) n_rows = cap;
    n = n_rows * eff_cols;
    if ($urandom_range(0, 3) == 0) n += $urandom_range(0, eff_cols - 1);
    pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
    stream_matrix(n, pause_at, 1'b1);
  endtask

  initial begin
    int start;
    int random_sent;
    elem_ch.valid         = 1'b0;
    elem_ch.kind          = KIND_VECTOR;
    elem_ch.element_value = '0;
    cfg_we                = 1'b0;
    cfg_idx               = REG_COLUMN_COUNT;
    cfg_wdata             = '0;
    rst_n                 = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset sizes: one column, one row, so every matrix element closes a matrix
    send_vector(32'h8000_0000);
    send_item(KIND_MATRIX, 32'h8000_0000);
    send_item(KIND_MATRIX, 32'h7FFF_FFFF);
    send_vector(32'hFFFF_FFFF);
    send_item(KIND_MATRIX, 32'hFFFF_FFFF);
    send_item(KIND_MATRIX, 32'h0000_0000);
    send_vector(32'h7FFF_FFFF);
    send_item(KIND_MATRIX, 32'h7FFF_FFFF);

    // zero sizes read as one
    set_sizes(0, 0);
    send_vector(32'd3);
    send_item(KIND_MATRIX, -32'sd5);

    // 3x2 with an overlong vector wrapping onto entry 0, sums that overflow,
    // and a new matrix started then cut short by the next register write
    set_sizes(3, 2);
    send_vector(32'h1234_5678);
    send_vector(32'h7FFF_FFFF);
    send_vector(32'h7FFF_FFFF);
    send_vector(32'h7FFF_FFFF);
    repeat (3) send_item(KIND_MATRIX, 32'h7FFF_FFFF);
    send_item(KIND_MATRIX, 32'h8000_0000);
    send_item(KIND_MATRIX, 32'hFFFF_FFFF);
    send_item(KIND_MATRIX, 32'h0000_0001);
    send_item(KIND_MATRIX, 32'h8000_0000);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      start = items_sent;
      random_phase();
      random_sent += items_sent - start;
    end

    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    settle();
    if (row_errors == 0 && rows_pending == 0) begin
      $display("matrix_vector_multiply test passed");
    end else begin
      $display("matrix_vector_multiply test failed");
    end
    $finish;
  end

endmodule
